FILE: hw/rtl/lgs_pkg.sv
// Package for the life generation step unit.
// Holds the configuration port constants, the register index codes and the
// stage control struct. No dependencies.
package lgs_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic wrap_view;
		logic top_edge;
		logic bottom_edge;
		logic left_edge;
		logic right_edge;
	} win_ctrl_t;

endpackage

FILE: hw/rtl/lgs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module lgs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/life_generation_step_unit.sv
// Top level of the life generation step unit: one B3/S23 generation over a raster stream.
// Depends on lgs_pkg and lgs_ram.
//
// The unit takes one cell per clock cycle and gives one result per cycle while out_ready
// holds; the request that completes a cell's neighbourhood passes an input register and a
// result register before the cell's result appears. The two previous rows live in one
// MAX_WIDTH by 2 bit RAM with a registered read, and a 3x3 window supplies the eight
// neighbours. Each result lags its input by grid_width + 1 requests, so after the grid the
// host sends grid_width + 1 flush requests; the result for the final cell carries last_cell,
// after which the next cell starts a new grid. Flush requests at the start of a grid are
// taken and ignored. Writing either register restarts the grid and must be done while idle.
module life_generation_step_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [lgs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cell_alive,
	input  logic                           flush,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           next_alive,
	output logic                           last_cell
);

	import lgs_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WCNT_W = COL_W + 1;
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

	logic [WCNT_W-1:0] grid_w_q;
	logic [ROW_W-1:0]  grid_h_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [8:0]        win_q;

	logic              s1_valid_s1;
	win_ctrl_t         ctrl_s1;
	logic              cell_s1;
	logic [COL_W-1:0]  addr_s1;
	logic              byp_s1;
	logic [1:0]        byp_data_s1;

	logic              out_valid_s2;
	logic              next_alive_s2;
	logic              last_cell_s2;

	logic              cfg_hit_w;
	logic              cfg_hit_h;
	logic [WCNT_W-1:0] cfg_w_val;
	logic [ROW_W-1:0]  cfg_h_val;

	logic              in_fire;
	logic              is_nop;
	logic              load_s1;
	logic              col_zero;
	logic [WCNT_W-1:0] col_inc;
	logic              row_wrap;
	logic [ROW_W-1:0]  h_plus1;
	win_ctrl_t         ctrl_d;
	logic              cell_d;

	logic [1:0]        ram_rdata;
	logic [1:0]        rd_word;
	logic              above;
	logic              middle;
	logic [8:0]        win_shift;
	logic [8:0]        view;
	logic [3:0]        n_count;
	logic              rule_alive;
	logic              fire1;

	// Configuration decode and range clamping.
	always_comb begin
		cfg_hit_w = 1'b0;
		cfg_hit_h = 1'b0;
		unique case (cfg_reg_t'(cfg_index))
			REG_GRID_WIDTH: begin
				cfg_hit_w = cfg_write_en;
			end
			REG_GRID_HEIGHT: begin
				cfg_hit_h = cfg_write_en;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (cfg_data == '0) begin
			cfg_w_val = WCNT_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
			cfg_w_val = WCNT_W'(MAX_WIDTH);
		end else begin
			cfg_w_val = WCNT_W'(cfg_data);
		end
		if (cfg_data == '0) begin
			cfg_h_val = ROW_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
			cfg_h_val = ROW_W'(MAX_HEIGHT);
		end else begin
			cfg_h_val = ROW_W'(cfg_data);
		end
	end

	// Input side: position tracking and per-request control.
	assign in_fire  = in_valid && in_ready;
	assign col_zero = (col_q == '0);
	assign is_nop   = flush && col_zero && (row_q == '0);
	assign load_s1  = in_fire && !is_nop;
	assign col_inc  = {1'b0, col_q} + WCNT_W'(1);
	assign row_wrap = (col_inc >= grid_w_q);
	assign h_plus1  = grid_h_q + ROW_W'(1);
	assign cell_d   = !flush && (row_q < grid_h_q) && cell_alive;

	always_comb begin
		ctrl_d.emit        = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && !col_zero);
		ctrl_d.last        = col_zero && (row_q == h_plus1);
		ctrl_d.wrap_view   = col_zero;
		ctrl_d.right_edge  = col_zero;
		if (col_zero) begin
			ctrl_d.top_edge    = (row_q == ROW_W'(2));
			ctrl_d.bottom_edge = (row_q >= h_plus1);
			ctrl_d.left_edge   = (grid_w_q == WCNT_W'(1));
		end else begin
			ctrl_d.top_edge    = (row_q == ROW_W'(1));
			ctrl_d.bottom_edge = (row_q >= grid_h_q);
			ctrl_d.left_edge   = (col_q == COL_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= WCNT_W'(MAX_WIDTH);
			grid_h_q <= ROW_W'(MAX_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_hit_w || cfg_hit_h) begin
			if (cfg_hit_w) begin
				grid_w_q <= cfg_w_val;
			end
			if (cfg_hit_h) begin
				grid_h_q <= cfg_h_val;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (load_s1) begin
			if (ctrl_d.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// Row store: bit 1 holds the row two above, bit 0 the row above.
	lgs_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_row_ram (
		.clk  (clk),
		.we   (fire1),
		.waddr(addr_s1),
		.wdata({middle, cell_s1}),
		.re   (load_s1),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// Stage 1: window update, neighbour count and rule.
	assign rd_word   = byp_s1 ? byp_data_s1 : ram_rdata;
	assign above     = rd_word[1];
	assign middle    = rd_word[0];
	assign win_shift = {cell_s1, win_q[8:7], middle, win_q[5:4], above, win_q[2:1]};
	assign view      = ctrl_s1.wrap_view ?
		{1'b0, win_q[8:7], 1'b0, win_q[5:4], 1'b0, win_q[2:1]} : win_shift;

	always_comb begin
		logic keep;
		n_count = '0;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				keep = !((k == 0) && ctrl_s1.top_edge) && !((k == 2) && ctrl_s1.bottom_edge)
					&& !((j == 0) && ctrl_s1.left_edge) && !((j == 2) && ctrl_s1.right_edge)
					&& !((k == 1) && (j == 1));
				n_count = n_count + 4'(keep && view[k*3+j]);
			end
		end
		rule_alive = (n_count == 4'd3) || (view[4] && (n_count == 4'd2));
	end

	assign fire1    = s1_valid_s1 && (!ctrl_s1.emit || !out_valid_s2 || out_ready);
	assign in_ready = !s1_valid_s1 || fire1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			win_q       <= '0;
		end else begin
			if (load_s1) begin
				s1_valid_s1 <= 1'b1;
			end else if (fire1) begin
				s1_valid_s1 <= 1'b0;
			end
			if (cfg_hit_w || cfg_hit_h) begin
				win_q <= '0;
			end else if (fire1) begin
				win_q <= ctrl_s1.last ? 9'd0 : win_shift;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			ctrl_s1     <= ctrl_d;
			cell_s1     <= cell_d;
			addr_s1     <= col_q;
			byp_s1      <= fire1 && (addr_s1 == col_q);
			byp_data_s1 <= {middle, cell_s1};
		end
	end

	// Stage 2: result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (fire1 && ctrl_s1.emit) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1 && ctrl_s1.emit) begin
			next_alive_s2 <= rule_alive;
			last_cell_s2  <= ctrl_s1.last;
		end
	end

	assign out_valid  = out_valid_s2;
	assign next_alive = next_alive_s2;
	assign last_cell  = last_cell_s2;

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < grid_w_q)
		else $error("column position beyond grid width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_plus1)
		else $error("row position beyond grid height plus one");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 && ctrl_d.last |=> (col_q == '0) && (row_q == '0))
		else $error("position not restarted after final cell");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && ctrl_s1.last |-> ctrl_s1.emit)
		else $error("final cell flagged on a request without result");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for life_generation_step_unit: streams raster grids of random sizes
// and content through the request handshake and checks every result against a B3/S23 predictor.
// Depends on lgs_pkg and the unit's RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lgs_pkg::*;

	localparam int GRID_MAX = 1024;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 2'd3;

	typedef struct packed {
		logic next_alive;
		logic last_cell;
	} life_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cell_alive = 1'b0;
	logic flush = 1'b0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic next_alive;
	logic last_cell;

	logic store_above [GRID_MAX];
	logic store_middle [GRID_MAX];
	logic [8:0] window;
	int unsigned col_pos, row_pos, emitted, grid_w, grid_h;
	life_result_t pending_cells[$];
	int unsigned cells_processed = 0;
	int unsigned fault_count = 0;
	int unsigned sender_gap_pct = 0;
	int unsigned receiver_stall_pct = 0;

	life_generation_step_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cell_alive(cell_alive),
		.flush(flush),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.next_alive(next_alive),
		.last_cell(last_cell)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	function automatic void restart_grid();
		window = '0;
		col_pos = 0;
		row_pos = 0;
		emitted = 0;
	endfunction

	function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] value);
		if (value == 0)
			return 1;
		if (value > GRID_MAX)
			return GRID_MAX;
		return 32'(value);
	endfunction

	function automatic void advance_life(logic alive, logic fl);
		int unsigned ic, ir, t, total, cr, cc, n;
		logic v, a, m, emit;
		logic [8:0] view;
		life_result_t res;
		if (fl && col_pos == 0 && row_pos == 0)
			return;
		cells_processed++;
		ic = col_pos;
		ir = row_pos;
		if (ic >= grid_w)
			ic = 0;
		v = (!fl && ir < grid_h) ? alive : 1'b0;
		a = store_above[ic];
		m = store_middle[ic];
		t = ir * grid_w + ic;
		total = grid_w * grid_h;
		emit = (t >= grid_w + 1) && (emitted < total);
		view = window;
		if (ic == 0)
			view = {1'b0, window[8:7], 1'b0, window[5:4], 1'b0, window[2:1]};
		window = {v, window[8:7], m, window[5:4], a, window[2:1]};
		if (ic != 0)
			view = window;
		store_above[ic] = m;
		store_middle[ic] = v;
		if (ic + 1 >= grid_w) begin
			col_pos = 0;
			row_pos = ir + 1;
		end else begin
			col_pos = ic + 1;
			row_pos = ir;
		end
		if (!emit)
			return;
		cr = emitted / grid_w;
		cc = emitted % grid_w;
		n = 0;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				if ((k == 0 && cr == 0) || (k == 2 && cr + 1 >= grid_h))
					continue;
				if ((k == 1 && j == 1) || (j == 0 && cc == 0) || (j == 2 && cc + 1 >= grid_w))
					continue;
				n += 32'(view[k * 3 + j]);
			end
		end
		res.next_alive = (n == 3) || (view[4] && n == 2);
		res.last_cell = (emitted + 1 == total);
		pending_cells.push_back(res);
		emitted++;
		if (emitted >= total)
			restart_grid();
	endfunction

	always @(posedge clk) begin
		life_result_t exp_cell;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cells.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: next_alive=%0b last_cell=%0b",
						next_alive, last_cell);
			end else begin
				exp_cell = pending_cells.pop_front();
				if (exp_cell.next_alive !== next_alive || exp_cell.last_cell !== last_cell) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: next_alive exp %0b got %0b, last_cell exp %0b got %0b",
							exp_cell.next_alive, next_alive, exp_cell.last_cell, last_cell);
				end
			end
		end
	end

	task automatic send_cell(input logic alive, input logic fl);
		while ($urandom_range(99) < sender_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cell_alive = alive;
		flush = fl;
		do @(posedge clk); while (!in_ready);
		advance_life(alive, fl);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_write_en = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write_en = 1'b0;
		if (idx == REG_GRID_WIDTH) begin
			grid_w = clamp_dim(value);
			restart_grid();
		end else if (idx == REG_GRID_HEIGHT) begin
			grid_h = clamp_dim(value);
			restart_grid();
		end
	endtask

	// Every outstanding result must have arrived before the registers may be touched.
	task automatic settle();
		in_valid = 1'b0;
		while (pending_cells.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic send_grid(input int unsigned live_pct, input int unsigned inner_flush_pct,
			input int unsigned trailer_cell_pct);
		int unsigned cells;
		cells = grid_w * grid_h;
		for (int unsigned i = 0; i < cells; i++)
			send_cell($urandom_range(99) < live_pct, $urandom_range(99) < inner_flush_pct);
		for (int unsigned i = 0; i <= grid_w; i++)
			send_cell(1'($urandom_range(1)), $urandom_range(99) >= trailer_cell_pct);
		repeat ($urandom_range(2))
			send_cell(1'($urandom_range(1)), 1'b1);
	endtask

	task automatic test_directed_cases();
		sender_gap_pct = 0;
		receiver_stall_pct = 0;
		write_register(REG_GRID_WIDTH, 11'd3);
		write_register(REG_GRID_HEIGHT, 11'd3);
		write_register(REG_UNUSED_LO, 11'($urandom));
		write_register(REG_UNUSED_HI, 11'h7FF);
		send_cell(1'b1, 1'b1);
		for (int i = 0; i < 9; i++)
			send_cell(i % 3 == 1, 1'b0);
		send_cell(1'b0, 1'b1);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b1);
		send_cell(1'b0, 1'b1);
		send_cell(1'b0, 1'b1);
		send_cell(1'b1, 1'b1);
		settle();
		write_register(REG_GRID_WIDTH, 11'd2);
		write_register(REG_GRID_HEIGHT, 11'd2);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b1);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		repeat (3) send_cell(1'b0, 1'b1);
		settle();
		write_register(REG_GRID_HEIGHT, 11'd0);
		write_register(REG_GRID_WIDTH, 11'd0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b0, 1'b1);
		settle();
	endtask

	task automatic test_random_grids();
		int unsigned phase_gap [4] = '{0, 45, 0, 35};
		int unsigned phase_stall [4] = '{0, 0, 45, 35};
		int unsigned goal, pick;
		logic [CFG_DATA_W-1:0] raw_w, raw_h;
		for (int p = 0; p < 4; p++) begin
			sender_gap_pct = phase_gap[p];
			receiver_stall_pct = phase_stall[p];
			goal = cells_processed + 160;
			while (cells_processed < goal) begin
				pick = $urandom_range(19);
				if (pick == 0)
					raw_w = '0;
				else if (pick == 1)
					raw_w = 11'd1;
				else if (pick < 15)
					raw_w = 11'($urandom_range(2, 6));
				else if (pick < 19)
					raw_w = 11'($urandom_range(7, 40));
				else
					raw_w = 11'($urandom_range(41, 120));
				pick = $urandom_range(19);
				if (raw_w > 40)
					raw_h = 11'($urandom_range(0, 2));
				else if (pick == 0)
					raw_h = '0;
				else if (pick < 16)
					raw_h = 11'($urandom_range(1, 8));
				else
					raw_h = 11'($urandom_range(9, 24));
				if ($urandom_range(1)) begin
					write_register(REG_GRID_WIDTH, raw_w);
					write_register(REG_GRID_HEIGHT, raw_h);
				end else begin
					write_register(REG_GRID_HEIGHT, raw_h);
					write_register(REG_GRID_WIDTH, raw_w);
				end
				repeat ($urandom_range(1, 3))
					send_grid($urandom_range(5, 95), $urandom_range(1) * 4, 15);
				settle();
			end
		end
	endtask

	// Both registers above their maximum: the first full row plus a few cells of the
	// second give the first results only if the width is held at its maximum.
	task automatic test_size_extremes();
		sender_gap_pct = 35;
		receiver_stall_pct = 35;
		write_register(REG_GRID_WIDTH, 11'h7FF);
		write_register(REG_GRID_HEIGHT, 11'h7FF);
		for (int unsigned i = 0; i < GRID_MAX + 4; i++)
			send_cell(1'($urandom_range(1)), 1'b0);
		settle();
	endtask

	initial begin
		for (int i = 0; i < GRID_MAX; i++) begin
			store_above[i] = 1'b0;
			store_middle[i] = 1'b0;
		end
		grid_w = GRID_MAX;
		grid_h = GRID_MAX;
		restart_grid();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_random_grids();
		test_size_extremes();
		settle();
		if (fault_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
